// ----- hdl/pbsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and byte functions for the pixel byte shuffle and premultiply block.
// Used by pbsp_lane, pbsp_merge and pixel_byte_shuffle_premultiply; depends on nothing.
package pbsp_pkg;

    localparam int PIXELS        = 4;
    localparam int LANES_DEFAULT = 4;
    localparam int COUNT_W       = 3;
    localparam int PIXEL_W       = 32;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [1:0] {
        MODE_SHUFFLE = 2'd0,
        MODE_EXPAND  = 2'd1,
        MODE_PREMUL  = 2'd2
    } conv_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 2'd0,
        REG_ALPHA     = 2'd1,
        REG_SELECTORS = 2'd2,
        REG_FILL      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic               alpha_leading;
        logic [PIXEL_W-1:0] selectors;
        logic [PIXEL_W-1:0] fill;
    } cfg_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctrl_t;

    function automatic logic [7:0] pick_byte(input logic [PIXEL_W-1:0] src,
                                             input logic [7:0] sel,
                                             input logic [1:0] mode);
        logic [3:0] nbytes;
        logic [7:0] b;
        nbytes = (mode == MODE_EXPAND) ? 4'd3 : 4'd4;
        b = 8'h00;
        if (!sel[7] && (sel[3:0] < nbytes)) begin
            b = src[8 * sel[1:0] +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] s;
        s = x + {8'h00, x[15:8]};
        return s[15:8];
    endfunction

endpackage

// ----- hdl/pbsp_lane.sv -----
`timescale 1ns / 1ps
// One conversion lane: byte shuffle, registered 8x8 alpha products, rounding divide and fill.
// Depends on pbsp_pkg.
module pbsp_lane (
    input  logic                          aclk,
    input  logic                          en,
    input  logic                          lane_on,
    input  logic [pbsp_pkg::PIXEL_W-1:0]  src,
    input  pbsp_pkg::cfg_t                cfg,
    output logic [pbsp_pkg::PIXEL_W-1:0]  pixel,
    output logic                          active
);

    logic [3:0][7:0]  bytes_reg;
    logic [3:0][7:0]  bytes_next;
    logic [7:0]       alpha_reg;
    logic [7:0]       alpha_next;
    logic             on1_reg;

    logic [3:0][15:0] prod_reg;
    logic [3:0][15:0] prod_next;
    logic [3:0]       bypass_reg;
    logic [3:0]       bypass_next;
    logic [3:0][7:0]  raw_reg;
    logic             on2_reg;

    logic [3:0][7:0]  res;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            bytes_next[k] = pbsp_pkg::pick_byte(src, cfg.selectors[8*k +: 8], cfg.mode);
        end
        alpha_next = cfg.alpha_leading ? bytes_next[3] : bytes_next[0];
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod_next[k]   = 16'(bytes_reg[k] * alpha_reg) + 16'd128;
            bypass_next[k] = (cfg.mode != pbsp_pkg::MODE_PREMUL) ||
                             (cfg.alpha_leading ? (k == 3) : (k == 0));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bytes_reg  <= bytes_next;
            alpha_reg  <= alpha_next;
            on1_reg    <= lane_on;
            prod_reg   <= prod_next;
            bypass_reg <= bypass_next;
            raw_reg    <= bytes_reg;
            on2_reg    <= on1_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            res[k] = bypass_reg[k] ? raw_reg[k] : pbsp_pkg::div255(prod_reg[k]);
        end
    end

    assign pixel  = res | cfg.fill;
    assign active = on2_reg;

endmodule

// ----- hdl/pbsp_merge.sv -----
`timescale 1ns / 1ps
// Output register that gathers the lane results, clears inactive pixels and holds the transfer.
// Depends on pbsp_pkg.
module pbsp_merge (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  pbsp_pkg::pipe_ctrl_t                             ctrl,
    input  logic [pbsp_pkg::PIXELS-1:0][pbsp_pkg::PIXEL_W-1:0] lane_pixel,
    input  logic [pbsp_pkg::PIXELS-1:0]                      lane_active,
    input  logic [pbsp_pkg::COUNT_W-1:0]                     count,
    output logic [pbsp_pkg::PIXELS-1:0][pbsp_pkg::PIXEL_W-1:0] dst,
    output logic [pbsp_pkg::COUNT_W-1:0]                     out_count,
    output logic                                             out_valid
);

    logic [pbsp_pkg::PIXELS-1:0][pbsp_pkg::PIXEL_W-1:0] dst_reg;
    logic [pbsp_pkg::PIXELS-1:0][pbsp_pkg::PIXEL_W-1:0] dst_next;
    logic [pbsp_pkg::COUNT_W-1:0]                     count_reg;
    logic                                             valid_reg;

    always_comb begin
        for (int i = 0; i < pbsp_pkg::PIXELS; i++) begin
            dst_next[i] = lane_active[i] ? lane_pixel[i] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.en) begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            dst_reg   <= dst_next;
            count_reg <= count;
        end
    end

    assign dst       = dst_reg;
    assign out_count = count_reg;
    assign out_valid = valid_reg;

endmodule

// ----- hdl/pixel_byte_shuffle_premultiply.sv -----
`timescale 1ns / 1ps
// Pixel byte shuffle and premultiply top level: configuration registers, lanes and output stage.
// Depends on pbsp_pkg, pbsp_lane and pbsp_merge.
//
// Each transfer carries up to four 32-bit pixels that are converted in parallel lanes, one lane
// per pixel, and the block takes one transfer every clock cycle while the pipeline advances.
// A result is registered after the byte shuffle, after the 8x8 alpha multipliers and in the
// output stage. The whole pipeline advances whenever the output register is empty or its
// transfer completes, so a held result stalls the input only while the consumer keeps
// m_ready low. Pixels at or past pixel_count come out as zero; the count is capped at the
// smaller of LANES and four. Configuration is written through cfg_wr_en, cfg_index and
// cfg_wr_data and should change only while no transfer is in flight.
module pixel_byte_shuffle_premultiply #(
    parameter int LANES = pbsp_pkg::LANES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pbsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbsp_pkg::PIXEL_W-1:0]    cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pbsp_pkg::PIXEL_W-1:0]    s_src_pixel_a,
    input  logic [pbsp_pkg::PIXEL_W-1:0]    s_src_pixel_b,
    input  logic [pbsp_pkg::PIXEL_W-1:0]    s_src_pixel_c,
    input  logic [pbsp_pkg::PIXEL_W-1:0]    s_src_pixel_d,
    input  logic [pbsp_pkg::COUNT_W-1:0]    s_pixel_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pbsp_pkg::PIXEL_W-1:0]    m_dst_pixel_a,
    output logic [pbsp_pkg::PIXEL_W-1:0]    m_dst_pixel_b,
    output logic [pbsp_pkg::PIXEL_W-1:0]    m_dst_pixel_c,
    output logic [pbsp_pkg::PIXEL_W-1:0]    m_dst_pixel_d,
    output logic [pbsp_pkg::COUNT_W-1:0]    m_out_count
);

    localparam int ACTIVE = (LANES < pbsp_pkg::PIXELS) ? LANES : pbsp_pkg::PIXELS;

    pbsp_pkg::cfg_t                       cfg_reg;
    logic                                 en;
    logic                                 v1_reg;
    logic                                 v2_reg;
    logic [pbsp_pkg::COUNT_W-1:0]         count_next;
    logic [pbsp_pkg::COUNT_W-1:0]         count1_reg;
    logic [pbsp_pkg::COUNT_W-1:0]         count2_reg;
    pbsp_pkg::pipe_ctrl_t                 ctrl;

    logic [pbsp_pkg::PIXELS-1:0][pbsp_pkg::PIXEL_W-1:0] src;
    logic [pbsp_pkg::PIXELS-1:0][pbsp_pkg::PIXEL_W-1:0] lane_pixel;
    logic [pbsp_pkg::PIXELS-1:0][pbsp_pkg::PIXEL_W-1:0] dst;
    logic [pbsp_pkg::PIXELS-1:0]                      lane_active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= pbsp_pkg::MODE_SHUFFLE;
            cfg_reg.alpha_leading <= 1'b1;
            cfg_reg.selectors     <= 32'h0302_0100;
            cfg_reg.fill          <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pbsp_pkg::REG_MODE:      cfg_reg.mode          <= cfg_wr_data[1:0];
                pbsp_pkg::REG_ALPHA:     cfg_reg.alpha_leading <= cfg_wr_data[0];
                pbsp_pkg::REG_SELECTORS: cfg_reg.selectors     <= cfg_wr_data;
                pbsp_pkg::REG_FILL:      cfg_reg.fill          <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign count_next = (s_pixel_count > pbsp_pkg::COUNT_W'(ACTIVE)) ?
                        pbsp_pkg::COUNT_W'(ACTIVE) : s_pixel_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            count1_reg <= count_next;
            count2_reg <= count1_reg;
        end
    end

    assign src[0] = s_src_pixel_a;
    assign src[1] = s_src_pixel_b;
    assign src[2] = s_src_pixel_c;
    assign src[3] = s_src_pixel_d;

    for (genvar i = 0; i < pbsp_pkg::PIXELS; i++) begin : g_lane
        if (i < ACTIVE) begin : g_on
            pbsp_lane u_lane (
                .aclk    (aclk),
                .en      (en),
                .lane_on (count_next > pbsp_pkg::COUNT_W'(i)),
                .src     (src[i]),
                .cfg     (cfg_reg),
                .pixel   (lane_pixel[i]),
                .active  (lane_active[i])
            );
        end else begin : g_off
            assign lane_pixel[i]  = '0;
            assign lane_active[i] = 1'b0;
        end
    end

    assign ctrl.en    = en;
    assign ctrl.valid = v2_reg;

    pbsp_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .lane_pixel  (lane_pixel),
        .lane_active (lane_active),
        .count       (count2_reg),
        .dst         (dst),
        .out_count   (m_out_count),
        .out_valid   (m_valid)
    );

    assign m_dst_pixel_a = dst[0];
    assign m_dst_pixel_b = dst[1];
    assign m_dst_pixel_c = dst[2];
    assign m_dst_pixel_d = dst[3];

endmodule
